/* design/bara_pkg.sv */
// ----------------------------------------------------------------------------
// bara_pkg: shared types and constants for the button auto-repeat block
// Widths, register map, reset values, item mode codes and a saturating add.
// ----------------------------------------------------------------------------
package bara_pkg;

  // button and time widths
  localparam int unsigned BUTTON_COUNT = 32;
  localparam int unsigned TIME_BITS    = 16;
  localparam int unsigned ELAPSED_W    = 12;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned NUM_REGS     = 6;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned DATA_W       = 32;

  typedef logic [BUTTON_COUNT-1:0] mask_t;
  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [ELAPSED_W-1:0]    elapsed_t;
  typedef logic [CFG_W-1:0]        cfg_t;

  localparam time_t TIME_MAX = '1;

  // item modes
  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_CLEAR = 1'b1
  } mode_e;

  // register index in the map (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_REPEAT_PERIOD = 3'd0,
    REG_SLOW_PERIOD   = 3'd1,
    REG_FAST_PERIOD   = 3'd2,
    REG_REPEAT_DELAY  = 3'd3,
    REG_ACCEL_DELAY   = 3'd4,
    REG_FAST_DELAY    = 3'd5
  } reg_idx_e;

  // register reset values (1/960 s units)
  localparam cfg_t RST_REPEAT_PERIOD = 16'd64;
  localparam cfg_t RST_SLOW_PERIOD   = 16'd32;
  localparam cfg_t RST_FAST_PERIOD   = 16'd16;
  localparam cfg_t RST_REPEAT_DELAY  = 16'd480;
  localparam cfg_t RST_ACCEL_DELAY   = 16'd1440;
  localparam cfg_t RST_FAST_DELAY    = 16'd2880;

  // saturating add of elapsed time onto a time value
  function automatic time_t sat_add(time_t a, elapsed_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS+1)'(b);
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

endpackage

/* design/button_auto_repeat_accel.sv */
// ----------------------------------------------------------------------------
// button_auto_repeat_accel: auto-repeat with acceleration for 32 buttons
// Shared phase clocks, per-button saturating hold times, repeat and accel
// pulse masks per tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one beat per frame tick (mode tick) or a clear
//   beat (mode clear) that zeroes the hold times picked by clear_mask_i.
//   A tick beat yields one result beat with repeat_mask_o and accel_mask_o;
//   a clear beat yields none.
//   The beat is captured in an input register, the per-button logic works
//   on it there and the result lands in the output register. One beat is
//   taken every cycle while the receiver does not stall; the figure is set
//   by the joint update of the three phase clocks and the 32 parallel
//   hold time adders and compares.
//   When the receiver stalls with a result waiting, the input register
//   still holds one more beat; after that in_stall_o rises until the output
//   register drains. Clear beats pass the input register even then.
//   Reset clears the hold times, the phase clocks and the valid flags and
//   loads the registers with their defaults. The APB port is always ready;
//   write the registers only while no beat is in flight.
// ----------------------------------------------------------------------------
module button_auto_repeat_accel (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  bara_pkg::elapsed_t       elapsed_i,
  input  bara_pkg::mask_t          held_mask_i,
  input  bara_pkg::mask_t          pressed_mask_i,
  input  bara_pkg::mask_t          clear_mask_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output bara_pkg::mask_t          repeat_mask_o,
  output bara_pkg::mask_t          accel_mask_o,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [bara_pkg::ADDR_W-1:0] paddr,
  input  logic [bara_pkg::DATA_W-1:0] pwdata,
  output logic [bara_pkg::DATA_W-1:0] prdata,
  output logic                     pready
);
  import bara_pkg::*;

  // configuration registers
  cfg_t repeat_period_q, slow_period_q, fast_period_q;
  cfg_t repeat_delay_q, accel_delay_q, fast_delay_q;

  logic     cfg_we;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_period_q <= RST_REPEAT_PERIOD;
      slow_period_q   <= RST_SLOW_PERIOD;
      fast_period_q   <= RST_FAST_PERIOD;
      repeat_delay_q  <= RST_REPEAT_DELAY;
      accel_delay_q   <= RST_ACCEL_DELAY;
      fast_delay_q    <= RST_FAST_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_REPEAT_PERIOD: repeat_period_q <= pwdata[CFG_W-1:0];
        REG_SLOW_PERIOD:   slow_period_q   <= pwdata[CFG_W-1:0];
        REG_FAST_PERIOD:   fast_period_q   <= pwdata[CFG_W-1:0];
        REG_REPEAT_DELAY:  repeat_delay_q  <= pwdata[CFG_W-1:0];
        REG_ACCEL_DELAY:   accel_delay_q   <= pwdata[CFG_W-1:0];
        REG_FAST_DELAY:    fast_delay_q    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_REPEAT_PERIOD: prdata = DATA_W'(repeat_period_q);
      REG_SLOW_PERIOD:   prdata = DATA_W'(slow_period_q);
      REG_FAST_PERIOD:   prdata = DATA_W'(fast_period_q);
      REG_REPEAT_DELAY:  prdata = DATA_W'(repeat_delay_q);
      REG_ACCEL_DELAY:   prdata = DATA_W'(accel_delay_q);
      REG_FAST_DELAY:    prdata = DATA_W'(fast_delay_q);
      default:           prdata = '0;
    endcase
  end

  // input register
  logic     s1_valid_q;
  mode_e    s1_mode_q;
  elapsed_t s1_elapsed_q;
  mask_t    s1_held_q, s1_pressed_q, s1_clear_q;

  // output register
  logic  out_valid_q;
  mask_t out_rep_q, out_acc_q;

  logic out_free, s1_adv, s1_tick, in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_tick    = s1_valid_q && (s1_mode_q == MODE_TICK);
  // a clear beat needs no result slot
  assign s1_adv     = s1_valid_q && (out_free || (s1_mode_q == MODE_CLEAR));
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_mode_q    <= mode_e'(mode_i);
      s1_elapsed_q <= elapsed_i;
      s1_held_q    <= held_mask_i;
      s1_pressed_q <= pressed_mask_i;
      s1_clear_q   <= clear_mask_i;
    end
  end

  // phase clocks
  time_t rep_clk_q, slow_clk_q, fast_clk_q;
  time_t rep_sum, slow_sum, fast_sum;
  logic  rep_fire, slow_fire, fast_fire;

  always_comb begin
    rep_sum   = sat_add(rep_clk_q, s1_elapsed_q);
    slow_sum  = sat_add(slow_clk_q, s1_elapsed_q);
    fast_sum  = sat_add(fast_clk_q, s1_elapsed_q);
    rep_fire  = rep_sum  >= TIME_BITS'(repeat_period_q);
    slow_fire = slow_sum >= TIME_BITS'(slow_period_q);
    fast_fire = fast_sum >= TIME_BITS'(fast_period_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_clk_q  <= '0;
      slow_clk_q <= '0;
      fast_clk_q <= '0;
    end else if (s1_adv && s1_tick) begin
      rep_clk_q  <= rep_fire  ? '0 : rep_sum;
      slow_clk_q <= slow_fire ? '0 : slow_sum;
      fast_clk_q <= fast_fire ? '0 : fast_sum;
    end
  end

  // per-button hold times and pulse decisions
  time_t hold_q [BUTTON_COUNT];
  time_t hold_d [BUTTON_COUNT];
  mask_t rep_d, acc_d;

  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      hold_d[i] = hold_q[i];
      rep_d[i]  = 1'b0;
      acc_d[i]  = 1'b0;
      if (s1_mode_q == MODE_CLEAR) begin
        if (s1_clear_q[i]) hold_d[i] = '0;
      end else if (!s1_held_q[i]) begin
        hold_d[i] = '0;
      end else begin
        hold_d[i] = sat_add(hold_q[i], s1_elapsed_q);
        rep_d[i]  = s1_pressed_q[i];
        acc_d[i]  = s1_pressed_q[i];
        // accel on slow clock, then fast clock
        if (hold_d[i] >= TIME_BITS'(accel_delay_q)) begin
          if (hold_d[i] < TIME_BITS'(fast_delay_q)) begin
            if (slow_fire) acc_d[i] = 1'b1;
          end else if (fast_fire) begin
            acc_d[i] = 1'b1;
          end
        end
        // plain repeat, accel follows it before the accel delay
        if (hold_d[i] >= TIME_BITS'(repeat_delay_q) && rep_fire) begin
          rep_d[i] = 1'b1;
          if (hold_d[i] < TIME_BITS'(accel_delay_q)) acc_d[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUTTON_COUNT; i++) hold_q[i] <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < BUTTON_COUNT; i++) hold_q[i] <= hold_d[i];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && s1_tick) begin
      out_rep_q <= rep_d;
      out_acc_q <= acc_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign repeat_mask_o = out_rep_q;
  assign accel_mask_o  = out_acc_q;

endmodule

/* test/repeat_pulse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeat_pulse_checker: predicts and checks the repeat and accel pulse masks
// Watches the input, result and register channels of the auto-repeat block,
// keeps its own hold times, phase clocks and register copy, and compares
// every result beat with the oldest predicted pulse pair.
// ----------------------------------------------------------------------------
module repeat_pulse_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          mode_i,
  input  bara_pkg::elapsed_t            elapsed_i,
  input  bara_pkg::mask_t               held_mask_i,
  input  bara_pkg::mask_t               pressed_mask_i,
  input  bara_pkg::mask_t               clear_mask_i,
  // result channel
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  bara_pkg::mask_t               repeat_mask_i,
  input  bara_pkg::mask_t               accel_mask_i,
  // register port
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [bara_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [bara_pkg::DATA_W-1:0]   pwdata_i,
  // status
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_count_o
);
  import bara_pkg::*;

  // phase clock slots
  localparam int PH_REPEAT = 0;
  localparam int PH_SLOW   = 1;
  localparam int PH_FAST   = 2;

  typedef struct packed {
    mask_t rep;
    mask_t acc;
  } pulse_t;

  cfg_t   cfg_q   [NUM_REGS];
  time_t  hold_q  [BUTTON_COUNT];
  time_t  phase_q [3];
  pulse_t due_pulses [$];

  // time plus elapsed, capped at the top of the time range
  function automatic time_t add_capped(time_t a, elapsed_t b);
    if (int'(a) + int'(b) > int'(TIME_MAX)) return TIME_MAX;
    return a + time_t'(b);
  endfunction

  // advance one phase clock, report whether it fired
  function automatic logic tick_phase(int k, elapsed_t dt, cfg_t period);
    phase_q[k] = add_capped(phase_q[k], dt);
    if (phase_q[k] >= period) begin
      phase_q[k] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one tick beat: update clocks and hold times, return the pulse masks
  function automatic pulse_t advance_tick(elapsed_t dt, mask_t held, mask_t pressed);
    pulse_t p;
    logic   fire_rep, fire_slow, fire_fast;
    time_t  h;
    p = '0;
    fire_rep  = tick_phase(PH_REPEAT, dt, cfg_q[REG_REPEAT_PERIOD]);
    fire_slow = tick_phase(PH_SLOW, dt, cfg_q[REG_SLOW_PERIOD]);
    fire_fast = tick_phase(PH_FAST, dt, cfg_q[REG_FAST_PERIOD]);
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      if (!held[b]) begin
        // released, or pressed without being held
        hold_q[b] = '0;
      end else begin
        if (pressed[b]) begin
          p.rep[b] = 1'b1;
          p.acc[b] = 1'b1;
        end
        h = add_capped(hold_q[b], dt);
        hold_q[b] = h;
        // accel follows the slow clock, then the fast clock
        if (h >= cfg_q[REG_ACCEL_DELAY]) begin
          if (h < cfg_q[REG_FAST_DELAY]) begin
            if (fire_slow) p.acc[b] = 1'b1;
          end else if (fire_fast) begin
            p.acc[b] = 1'b1;
          end
        end
        // plain repeat, which also drives accel before the accel delay
        if (h >= cfg_q[REG_REPEAT_DELAY] && fire_rep) begin
          p.rep[b] = 1'b1;
          if (h < cfg_q[REG_ACCEL_DELAY]) p.acc[b] = 1'b1;
        end
      end
    end
    return p;
  endfunction

  // follow the channels on every clock
  always @(posedge clk_i or negedge rst_ni) begin : track
    pulse_t want;
    if (!rst_ni) begin
      cfg_q[REG_REPEAT_PERIOD] = RST_REPEAT_PERIOD;
      cfg_q[REG_SLOW_PERIOD]   = RST_SLOW_PERIOD;
      cfg_q[REG_FAST_PERIOD]   = RST_FAST_PERIOD;
      cfg_q[REG_REPEAT_DELAY]  = RST_REPEAT_DELAY;
      cfg_q[REG_ACCEL_DELAY]   = RST_ACCEL_DELAY;
      cfg_q[REG_FAST_DELAY]    = RST_FAST_DELAY;
      for (int b = 0; b < BUTTON_COUNT; b++) hold_q[b] = '0;
      for (int k = 0; k < 3; k++) phase_q[k] = '0;
      due_pulses.delete();
      mismatch_count_o = 0;
      pending_count_o <= 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (due_pulses.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got repeat %h accel %h",
                   $time, repeat_mask_i, accel_mask_i);
          mismatch_count_o++;
        end else begin
          want = due_pulses.pop_front();
          if (repeat_mask_i !== want.rep) begin
            $display("%0t: repeat_mask expected %h got %h", $time, want.rep, repeat_mask_i);
            mismatch_count_o++;
          end
          if (accel_mask_i !== want.acc) begin
            $display("%0t: accel_mask expected %h got %h", $time, want.acc, accel_mask_i);
            mismatch_count_o++;
          end
        end
      end
      // input beat
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == MODE_CLEAR) begin
          for (int b = 0; b < BUTTON_COUNT; b++)
            if (clear_mask_i[b]) hold_q[b] = '0;
        end else begin
          due_pulses.push_back(advance_tick(elapsed_i, held_mask_i, pressed_mask_i));
        end
      end
      // register write, out-of-range index ignored
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[ADDR_W-1:2] < NUM_REGS)
        cfg_q[paddr_i[ADDR_W-1:2]] = pwdata_i[CFG_W-1:0];
      pending_count_o <= due_pulses.size();
    end
  end

endmodule

/* test/tb_button_auto_repeat_accel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_auto_repeat_accel: stimulus and verdict for the auto-repeat block
// Drives a directed run over the field extremes, then random phases of
// realistic button holds with some noise and clear beats under several
// register settings, with random gaps and stalls on both channels and one
// long result hold-off. Checking is done by repeat_pulse_checker.
// ----------------------------------------------------------------------------
module tb_button_auto_repeat_accel;
  import bara_pkg::*;

  localparam int unsigned MAX_WAIT        = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned DRAIN_LIMIT     = 4000;
  localparam int unsigned PHASE_COUNT     = 5;
  localparam int unsigned PHASE_ITEMS     = 120;
  localparam int unsigned CHUNK_ITEMS     = 40;
  localparam elapsed_t    FRAME_UNITS     = 16;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i         = MODE_TICK;
  elapsed_t             elapsed_i      = '0;
  mask_t                held_mask_i    = '0;
  mask_t                pressed_mask_i = '0;
  mask_t                clear_mask_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  mask_t                repeat_mask_o;
  mask_t                accel_mask_o;
  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [ADDR_W-1:0]    paddr          = '0;
  logic [DATA_W-1:0]    pwdata         = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  int unsigned          mismatch_count;
  int unsigned          pending_count;
  mask_t                held_now         = '0;
  logic                 tx_calm          = 1'b0;
  logic                 rx_calm          = 1'b0;
  int unsigned          hold_offs_wanted = 0;
  int unsigned          hold_offs_done   = 0;

  always #1 clk_i = ~clk_i;

  button_auto_repeat_accel dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .elapsed_i      (elapsed_i),
    .held_mask_i    (held_mask_i),
    .pressed_mask_i (pressed_mask_i),
    .clear_mask_i   (clear_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .repeat_mask_o  (repeat_mask_o),
    .accel_mask_o   (accel_mask_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  repeat_pulse_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .mode_i           (mode_i),
    .elapsed_i        (elapsed_i),
    .held_mask_i      (held_mask_i),
    .pressed_mask_i   (pressed_mask_i),
    .clear_mask_i     (clear_mask_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .repeat_mask_i    (repeat_mask_o),
    .accel_mask_i     (accel_mask_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // run limit
  initial begin : watchdog
    #1_000_000;
    $display("tb_button_auto_repeat_accel: FAIL");
    $finish;
  end

  function automatic int unsigned draw_wait(logic calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // mostly one frame, sometimes short, long or extreme steps
  function automatic elapsed_t pick_elapsed();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return FRAME_UNITS;
    if (r < 8) return elapsed_t'($urandom_range(0, 64));
    if (r < 9) return elapsed_t'($urandom);
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  // offer one beat after a random gap, hold it until taken
  task automatic send_item(mode_e m, elapsed_t dt, mask_t held, mask_t pressed, mask_t clr);
    int unsigned gap;
    gap = draw_wait(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    elapsed_i      <= dt;
    held_mask_i    <= held;
    pressed_mask_i <= pressed;
    clear_mask_i   <= clr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // setup then access cycle, upper data bits random
  task automatic write_reg(logic [ADDR_W-1:0] addr, cfg_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(cfg_t rep_per, cfg_t slow_per, cfg_t fast_per,
                                cfg_t rep_dly, cfg_t acc_dly, cfg_t fast_dly);
    write_reg(ADDR_W'(REG_REPEAT_PERIOD * 4), rep_per);
    write_reg(ADDR_W'(REG_SLOW_PERIOD * 4), slow_per);
    write_reg(ADDR_W'(REG_FAST_PERIOD * 4), fast_per);
    write_reg(ADDR_W'(REG_REPEAT_DELAY * 4), rep_dly);
    write_reg(ADDR_W'(REG_ACCEL_DELAY * 4), acc_dly);
    write_reg(ADDR_W'(REG_FAST_DELAY * 4), fast_dly);
  endtask

  // stop offering, wait for every result, then let the pipe settle
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (pending_count != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly realistic holds with rare toggles, some noise and clear beats
  task automatic send_random();
    int unsigned pick;
    mask_t       toggles;
    mask_t       held;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_item(MODE_CLEAR, elapsed_t'($urandom), $urandom, $urandom,
                ($urandom_range(0, 3) == 0) ? '1 : mask_t'($urandom));
    end else if (pick < 16) begin
      send_item(MODE_TICK, pick_elapsed(), $urandom, $urandom, $urandom);
    end else begin
      toggles = $urandom & $urandom & $urandom & $urandom & $urandom & $urandom;
      held    = held_now ^ toggles;
      send_item(MODE_TICK, pick_elapsed(), held, held & ~held_now, $urandom);
      held_now = held;
    end
  endtask

  // result side: random stalls, plus the long hold-off when asked
  initial begin : result_sink
    int unsigned n;
    forever begin
      if (hold_offs_done < hold_offs_wanted) begin
        n = HOLD_OFF_CYCLES;
        hold_offs_done++;
      end else begin
        n = draw_wait(rx_calm);
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // writes past the register map must be ignored
    write_reg(ADDR_W'(NUM_REGS * 4), '1);
    write_reg(ADDR_W'((NUM_REGS + 1) * 4), '0);

    // idle tick, full press, long hold
    send_item(MODE_TICK, '0, '0, '0, '1);
    send_item(MODE_TICK, FRAME_UNITS, '1, '1, '0);
    send_item(MODE_TICK, '1, '1, '0, '0);
    // pressed without held counts as released
    send_item(MODE_TICK, '1, 32'h0000_ffff, 32'hffff_0000, '1);
    // clear beat with every other field set
    send_item(MODE_CLEAR, '1, '1, '1, 32'haaaa_aaaa);
    // hold everything until the hold times saturate
    repeat (17) send_item(MODE_TICK, '1, '1, '0, 32'h5555_5555);
    // release all
    send_item(MODE_TICK, FRAME_UNITS, '0, '0, '0);

    // random phases under different register settings
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          // reset values, with the long hold-off at the start
          hold_offs_wanted = 1;
        end
        1: apply_settings('0, '0, '0, '0, '0, '0);
        2: apply_settings('1, '1, '1, '1, '1, '1);
        3: apply_settings(16'd1, 16'd1, 16'd1, 16'd16, 16'd48, 16'd96);
        default: begin
          apply_settings(cfg_t'($urandom_range(0, 200)), cfg_t'($urandom_range(0, 200)),
                         cfg_t'($urandom_range(0, 200)), cfg_t'($urandom_range(0, 4000)),
                         cfg_t'($urandom_range(0, 4000)), cfg_t'($urandom_range(0, 4000)));
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % CHUNK_ITEMS == 0) begin
          tx_calm = (ph == 0 && i == 0) || ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        send_random();
      end
    end

    wait_drained();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_button_auto_repeat_accel: PASS");
    end else begin
      $display("tb_button_auto_repeat_accel: FAIL");
    end
    $finish;
  end

endmodule
